@@ rtl/ncc_pkg.sv @@
// Package for the nearest centroid classifier.
// Holds the operation codes, field widths and saturation limit shared by the importing files.
// No dependencies.
package ncc_pkg;

   typedef enum logic [0:0] {
      OP_LOAD     = 1'b0,
      OP_CLASSIFY = 1'b1
   } ncc_op_type;

   localparam int VALUE_W   = 16;
   localparam int DIFF_W    = 17;
   localparam int SQ_W      = 32;
   localparam int SUM_W     = 38;
   localparam int CLUSTER_W = 3;
   localparam int FEATURE_W = 6;
   localparam int CSR_W     = 4;
   localparam int LANE_CAP  = 8;

   localparam logic [CSR_W-1:0] CSR_RESET = 4'd8;
   localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

endpackage

@@ rtl/ncc_req_if.sv @@
// Input channel of the nearest centroid classifier: valid, ready and one item.
// Depends on ncc_pkg for the field widths.
interface ncc_req_if import ncc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [CLUSTER_W-1:0] centroid_index;
   logic [FEATURE_W-1:0] feature_index;
   logic signed [VALUE_W-1:0] value;
   logic                 last_feature;

   modport source (output valid, operation, centroid_index, feature_index, value,
                   last_feature, input ready);
   modport sink   (input valid, operation, centroid_index, feature_index, value,
                   last_feature, output ready);
endinterface

@@ rtl/ncc_rsp_if.sv @@
// Result channel of the nearest centroid classifier: valid, ready and one result.
// Depends on ncc_pkg for the field widths.
interface ncc_rsp_if import ncc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CLUSTER_W-1:0] cluster;
   logic [SUM_W-1:0]     min_distance;

   modport source (output valid, cluster, min_distance, input ready);
   modport sink   (input valid, cluster, min_distance, output ready);
endinterface

@@ rtl/ncc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ncc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/ncc_lanes.sv @@
// Centroid store and per-cluster lanes: read, square of the difference, running sums.
// Depends on ncc_pkg and ncc_ram.
module ncc_lanes import ncc_pkg::*; #(
   parameter int LANES        = 8,
   parameter int MAX_FEATURES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      accept,
   input  logic                      operation,
   input  logic [CLUSTER_W-1:0]      centroid_index,
   input  logic [FEATURE_W-1:0]      feature_index,
   input  logic signed [VALUE_W-1:0] value,
   input  logic                      last_feature,
   output logic                      fin_valid,
   output logic [SUM_W-1:0]          fin_sums [LANES]
);
   localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   logic                  feature_hit;
   logic [ADDR_W+FEATURE_W-1:0] feature_wide;
   logic [ADDR_W-1:0]     addr;
   logic                  is_classify;
   logic [VALUE_W-1:0]    centroid [LANES];

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_last_ff;
   logic                  s1_hit_ff;
   logic signed [VALUE_W-1:0] s1_value_ff;

   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_last_ff;
   logic                  s2_hit_ff;
   logic [SQ_W-1:0]       sq_ff [LANES];
   logic [SQ_W-1:0]       sq_in [LANES];

   logic [SUM_W-1:0]      sums_ff [LANES];
   logic [SUM_W-1:0]      sums_in [LANES];
   logic [SUM_W-1:0]      total [LANES];
   logic                  fin_valid_ff, fin_valid_in;
   logic [SUM_W-1:0]      fin_sums_ff [LANES];

   assign feature_hit  = 32'(feature_index) < 32'(MAX_FEATURES);
   assign feature_wide = {{ADDR_W{1'b0}}, feature_index};
   assign addr         = feature_wide[ADDR_W-1:0];
   assign is_classify  = operation == OP_CLASSIFY;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic                     wr_en;
      logic signed [DIFF_W-1:0] diff;
      logic signed [2*DIFF_W-1:0] prod;
      logic [SUM_W:0]           acc;

      assign wr_en = accept && !is_classify && feature_hit &&
                     (centroid_index == CLUSTER_W'(i));

      ncc_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_FEATURES)) u_store (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (addr),
         .wr_data (value),
         .rd_en   (advance),
         .rd_addr (addr),
         .rd_data (centroid[i])
      );

      assign diff     = DIFF_W'(s1_value_ff) - DIFF_W'($signed(centroid[i]));
      assign prod     = diff * diff;
      assign sq_in[i] = prod[SQ_W-1:0];

      assign acc      = {1'b0, sums_ff[i]} + (SUM_W+1)'(sq_ff[i]);
      assign total[i] = !s2_hit_ff ? sums_ff[i] : (acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0]);
      assign sums_in[i] = (s2_valid_ff && s2_last_ff) ? '0 :
                          (s2_valid_ff ? total[i] : sums_ff[i]);
   end

   assign s1_valid_in  = accept && is_classify;
   assign s2_valid_in  = s1_valid_ff;
   assign fin_valid_in = s2_valid_ff && s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            sums_ff[i] <= '0;
         end
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         fin_valid_ff <= fin_valid_in;
         for (int i = 0; i < LANES; i++) begin
            sums_ff[i] <= sums_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff  <= last_feature;
         s1_hit_ff   <= feature_hit;
         s1_value_ff <= value;
         s2_last_ff  <= s1_last_ff;
         s2_hit_ff   <= s1_hit_ff;
         for (int i = 0; i < LANES; i++) begin
            sq_ff[i]       <= sq_in[i];
            fin_sums_ff[i] <= total[i];
         end
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin_sums  = fin_sums_ff;
endmodule

@@ rtl/ncc_argmin.sv @@
// Minimum search over the final sums of a point and the result register.
// Depends on ncc_pkg and ncc_rsp_if.
module ncc_argmin import ncc_pkg::*; #(
   parameter int LANES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CSR_W-1:0] clusters_in_use,
   input  logic             fin_valid,
   input  logic [SUM_W-1:0] fin_sums [LANES],
   output logic             advance,
   ncc_rsp_if.source        rsp_chan
);
   typedef struct packed {
      logic                 active;
      logic [CLUSTER_W-1:0] index;
      logic [SUM_W-1:0]     distance;
   } cand_type;

   // Between active candidates, the lower-indexed one wins only when strictly smaller, so ties go high.
   function automatic cand_type pick(input cand_type lo, input cand_type hi);
      cand_type res;
      if (lo.active && (!hi.active || (lo.distance < hi.distance))) begin
         res = lo;
      end else begin
         res = hi;
      end
      return res;
   endfunction

   logic [CSR_W-1:0]     active_n;
   cand_type             leaf [LANE_CAP];
   cand_type             lvl1 [LANE_CAP/2];
   cand_type             lvl2 [LANE_CAP/4];
   cand_type             best;
   logic                 load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CLUSTER_W-1:0] cluster_ff;
   logic [SUM_W-1:0]     distance_ff;

   always_comb begin
      if (clusters_in_use == '0) begin
         active_n = CSR_W'(1);
      end else if (32'(clusters_in_use) > 32'(LANES)) begin
         active_n = CSR_W'(LANES);
      end else begin
         active_n = clusters_in_use;
      end
   end

   for (genvar i = 0; i < LANE_CAP; i++) begin : g_leaf
      if (i < LANES) begin : g_used
         assign leaf[i] = '{active: CSR_W'(i) < active_n, index: CLUSTER_W'(i),
                            distance: fin_sums[i]};
      end else begin : g_unused
         assign leaf[i] = '{active: 1'b0, index: CLUSTER_W'(i), distance: '0};
      end
   end

   always_comb begin
      for (int i = 0; i < LANE_CAP/2; i++) begin
         lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
      end
      for (int i = 0; i < LANE_CAP/4; i++) begin
         lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
      end
      best = pick(lvl2[0], lvl2[1]);
   end

   assign advance      = !(fin_valid && rsp_valid_ff && !rsp_chan.ready);
   assign load         = fin_valid && advance;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cluster_ff  <= best.index;
         distance_ff <= best.distance;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.cluster      = cluster_ff;
   assign rsp_chan.min_distance = distance_ff;
endmodule

@@ rtl/nearest_centroid_classifier.sv @@
// Top level of the nearest centroid classifier (k-means assignment step).
// Depends on ncc_pkg, ncc_req_if, ncc_rsp_if, ncc_lanes and ncc_argmin.
//
//   Port       Role     Moves
//   req_chan   sink     one word: centroid element load or one point feature
//   rsp_chan   source   one word: nearest cluster and its squared distance
//   csr_*      write    clusters_in_use, taken whenever the write enable is high
//
// One word is taken every cycle while ready is high; the last feature of a point passes the
// store read, squaring and final-sum registers before its result enters the output register.
// The store read, the squaring stage and the running-sum stage each hold one register level.
// Reset clears the running sums, the stage valid flags and sets clusters_in_use to 8.
// Ready falls only while a result waits in the output register and another waits
// behind it.
module nearest_centroid_classifier import ncc_pkg::*; #(
   parameter int MAX_CLUSTERS = 8,
   parameter int MAX_FEATURES = 64
) (
   input  logic             clock,
   input  logic             reset,
   ncc_req_if.sink          req_chan,
   ncc_rsp_if.source        rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CSR_W-1:0] csr_write_data
);
   localparam int LANES = (MAX_CLUSTERS < LANE_CAP) ? MAX_CLUSTERS : LANE_CAP;

   logic             advance;
   logic             accept;
   logic             fin_valid;
   logic [SUM_W-1:0] fin_sums [LANES];
   logic [CSR_W-1:0] clusters_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= CSR_RESET;
      end else if (csr_write_enable) begin
         clusters_ff <= csr_write_data;
      end
   end

   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   ncc_lanes #(.LANES(LANES), .MAX_FEATURES(MAX_FEATURES)) u_lanes (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .accept         (accept),
      .operation      (req_chan.operation),
      .centroid_index (req_chan.centroid_index),
      .feature_index  (req_chan.feature_index),
      .value          (req_chan.value),
      .last_feature   (req_chan.last_feature),
      .fin_valid      (fin_valid),
      .fin_sums       (fin_sums)
   );

   ncc_argmin #(.LANES(LANES)) u_argmin (
      .clock           (clock),
      .reset           (reset),
      .clusters_in_use (clusters_ff),
      .fin_valid       (fin_valid),
      .fin_sums        (fin_sums),
      .advance         (advance),
      .rsp_chan        (rsp_chan)
   );
endmodule
